/* hw/rtl/tfws_pkg.sv */
// ----------------------------------------------------------------------------
// tfws_pkg
// Shared types and constants for the four-weight select block: the input
// and result words and the slot record that each cell of the chain holds.
// ----------------------------------------------------------------------------
package tfws_pkg;

    localparam int WeightW    = 16;
    localparam int BoneW      = 8;
    localparam int OutSlots   = 4;
    localparam int KeepSlotsD = 4;

    // One influence pair as it arrives
    typedef struct packed {
        logic [BoneW-1:0]   bone_id;
        logic [WeightW-1:0] weight;
        logic               has_pair;
        logic               last;
    } t_in_word;

    // Four kept weights and their bone indices, largest first
    typedef struct packed {
        logic [WeightW-1:0] weight_first;
        logic [WeightW-1:0] weight_second;
        logic [WeightW-1:0] weight_third;
        logic [WeightW-1:0] weight_fourth;
        logic [BoneW-1:0]   index_first;
        logic [BoneW-1:0]   index_second;
        logic [BoneW-1:0]   index_third;
        logic [BoneW-1:0]   index_fourth;
    } t_out_word;

    // Contents of one slot cell
    typedef struct packed {
        logic               used;
        logic [WeightW-1:0] weight;
        logic [BoneW-1:0]   bone;
    } t_slot;

    // Per-cycle controls shared by every cell
    typedef struct packed {
        logic step;
        logic clear;
    } t_cell_ctrl;

endpackage

/* hw/rtl/top_four_weight_select.sv */
// ----------------------------------------------------------------------------
// top_four_weight_select
// Keeps the four heaviest bone influences of a vertex in a chain of sorted
// slot cells and emits them, largest first, on the vertex's last word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_word
//  out     | output    | o_out_valid / i_out_stall | o_out_word
//
//  One word is taken every cycle unless stalled; each is sorted into the slot
//  chain in the cycle it is accepted; a result appears the cycle after its last
//  word. The single chain update of compare and shift per cycle sets that rate.
//  Reset (synchronous, active low) empties all slots and the output register.
//  A stalled output holds its word; input words keep flowing, and only a last
//  word waits while the output register is full and stalled.
// ----------------------------------------------------------------------------
module top_four_weight_select #(
    parameter int KEEP_SLOTS = tfws_pkg::KeepSlotsD
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tfws_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tfws_pkg::t_out_word o_out_word
);
    import tfws_pkg::*;

    logic       w_in_acc;
    t_cell_ctrl w_ctrl;
    t_slot      w_new;
    t_slot      w_slot [KEEP_SLOTS];
    t_slot      w_next [KEEP_SLOTS];
    logic       w_take [KEEP_SLOTS];
    logic [KEEP_SLOTS-1:0] w_used;

    logic [WeightW-1:0] w_ow [OutSlots];
    logic [BoneW-1:0]   w_ob [OutSlots];
    t_out_word          n_out_word;

    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       w_out_load;

    // Hold only a last word while the result register cannot drain
    assign o_in_stall = r_out_valid && i_out_stall && i_in_word.last;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_ctrl.step  = w_in_acc && i_in_word.has_pair;
    assign w_ctrl.clear = w_in_acc && i_in_word.last;

    assign w_new.used   = 1'b1;
    assign w_new.weight = i_in_word.weight;
    assign w_new.bone   = i_in_word.bone_id;

    // Slot chain, heaviest at cell zero
    for (genvar k = 0; k < KEEP_SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            tfws_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_new       (w_new),
                .i_left      (w_new),
                .i_left_take (1'b0),
                .o_take      (w_take[k]),
                .o_slot      (w_slot[k]),
                .o_next      (w_next[k])
            );
        end else begin : g_body
            tfws_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_new       (w_new),
                .i_left      (w_slot[k-1]),
                .i_left_take (w_take[k-1]),
                .o_take      (w_take[k]),
                .o_slot      (w_slot[k]),
                .o_next      (w_next[k])
            );
        end
        assign w_used[k] = w_slot[k].used;
    end

    // Gather the first four slots after this word's insert; empty reads as zero
    for (genvar j = 0; j < OutSlots; j++) begin : g_out
        if (j < KEEP_SLOTS) begin : g_kept
            assign w_ow[j] = w_next[j].used ? w_next[j].weight : '0;
            assign w_ob[j] = w_next[j].used ? w_next[j].bone   : '0;
        end else begin : g_pad
            assign w_ow[j] = '0;
            assign w_ob[j] = '0;
        end
    end

    assign n_out_word.weight_first  = w_ow[0];
    assign n_out_word.weight_second = w_ow[1];
    assign n_out_word.weight_third  = w_ow[2];
    assign n_out_word.weight_fourth = w_ow[3];
    assign n_out_word.index_first   = w_ob[0];
    assign n_out_word.index_second  = w_ob[1];
    assign n_out_word.index_third   = w_ob[2];
    assign n_out_word.index_fourth  = w_ob[3];

    // Result register: advance when empty or drained
    assign w_out_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_ctrl.clear;
        end
        if (w_out_load && w_ctrl.clear) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> o_out_valid)
        else $error("no result after last word");

    a_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> ($countones(w_used) == 0))
        else $error("slots not cleared after last word");

    for (genvar k = 1; k < KEEP_SLOTS; k++) begin : g_chk
        a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_slot[k].used |-> w_slot[k-1].used)
            else $error("slot used behind an empty slot");

        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_slot[k].used |-> (w_slot[k-1].weight >= w_slot[k].weight))
            else $error("slot chain out of order");
    end

endmodule

/* hw/rtl/tfws_cell.sv */
// ----------------------------------------------------------------------------
// tfws_cell
// One slot of the sorted chain. Decides whether a new pair lands at or before
// this slot, then loads the new pair, takes the left neighbor's slot, or holds.
// ----------------------------------------------------------------------------
module tfws_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfws_pkg::t_cell_ctrl i_ctrl,
    input  tfws_pkg::t_slot     i_new,
    input  tfws_pkg::t_slot     i_left,
    input  logic                i_left_take,
    output logic                o_take,
    output tfws_pkg::t_slot     o_slot,
    output tfws_pkg::t_slot     o_next
);
    import tfws_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    t_slot w_after;

    // New pair goes at or before this slot: slot empty or strictly lighter
    assign o_take = !r_slot.used || (i_new.weight > r_slot.weight);

    // Insert here, shift in from the left, or hold
    always_comb begin
        w_after = r_slot;
        if (i_ctrl.step && o_take) begin
            if (i_left_take) begin
                w_after = i_left;
            end else begin
                w_after = i_new;
            end
        end
    end

    // Drop everything after the last word of a vertex
    always_comb begin
        n_slot = w_after;
        if (i_ctrl.clear) begin
            n_slot.used = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.used <= 1'b0;
        end else begin
            r_slot.used <= n_slot.used;
        end
        r_slot.weight <= n_slot.weight;
        r_slot.bone   <= n_slot.bone;
    end

    assign o_slot = r_slot;
    assign o_next = w_after;

endmodule

/* tb/tb_top_four_weight_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_four_weight_select
// Feeds vertices of bone influence pairs into the four-weight select block
// and checks each emitted set of four weights and indices against a stable
// top-four insertion sort kept alongside the block. The input side sends in
// bursts with random gaps, the output side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_top_four_weight_select;
    import tfws_pkg::*;

    // Tracks the kept slots of the current vertex and the sets still due
    class vertex_top4_board;
        localparam int Keep = tfws_pkg::KeepSlotsD;

        logic [WeightW-1:0] kept_weight[Keep];
        logic [BoneW-1:0]   kept_bone[Keep];
        bit                 kept_used[Keep];
        t_out_word          due_sets[$];
        int                 n_bad;
        int                 n_told;

        function new();
            n_bad  = 0;
            n_told = 0;
            empty_slots();
        endfunction

        function void empty_slots();
            for (int k = 0; k < Keep; k++) begin
                kept_weight[k] = '0;
                kept_bone[k]   = '0;
                kept_used[k]   = 1'b0;
            end
        endfunction

        // Insert after every kept pair of equal weight; drop if nothing is smaller
        function void sort_in_pair(logic [BoneW-1:0] bone, logic [WeightW-1:0] w);
            int pos;
            pos = Keep;
            for (int k = 0; k < Keep; k++) begin
                if (!kept_used[k] || w > kept_weight[k]) begin
                    pos = k;
                    break;
                end
            end
            if (pos < Keep) begin
                for (int k = Keep - 1; k > pos; k--) begin
                    kept_weight[k] = kept_weight[k-1];
                    kept_bone[k]   = kept_bone[k-1];
                    kept_used[k]   = kept_used[k-1];
                end
                kept_weight[pos] = w;
                kept_bone[pos]   = bone;
                kept_used[pos]   = 1'b1;
            end
        endfunction

        // Update the slots with an accepted word; queue a set on the last word
        function void note_word(t_in_word w);
            logic [WeightW-1:0] ow[OutSlots];
            logic [BoneW-1:0]   ob[OutSlots];
            t_out_word          set;
            if (w.has_pair) sort_in_pair(w.bone_id, w.weight);
            if (w.last) begin
                for (int k = 0; k < OutSlots; k++) begin
                    ow[k] = '0;
                    ob[k] = '0;
                    if (k < Keep && kept_used[k]) begin
                        ow[k] = kept_weight[k];
                        ob[k] = kept_bone[k];
                    end
                end
                set.weight_first  = ow[0];
                set.weight_second = ow[1];
                set.weight_third  = ow[2];
                set.weight_fourth = ow[3];
                set.index_first   = ob[0];
                set.index_second  = ob[1];
                set.index_third   = ob[2];
                set.index_fourth  = ob[3];
                due_sets.insert(due_sets.size(), set);
                empty_slots();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                n_bad++;
                if (n_told < 10) begin
                    n_told++;
                    $display("mismatch %s: expected %04h, got %04h", name, want, got);
                end
            end
        endfunction

        // Compare one accepted set with the oldest one due
        function void check_result(t_out_word got);
            t_out_word want;
            if (due_sets.size() == 0) begin
                n_bad++;
                if (n_told < 10) begin
                    n_told++;
                    $display("unexpected result word %h", got);
                end
                return;
            end
            want = due_sets.pop_front();
            compare_field("weight_first",  want.weight_first,  got.weight_first);
            compare_field("weight_second", want.weight_second, got.weight_second);
            compare_field("weight_third",  want.weight_third,  got.weight_third);
            compare_field("weight_fourth", want.weight_fourth, got.weight_fourth);
            compare_field("index_first",   {8'h00, want.index_first},
                          {8'h00, got.index_first});
            compare_field("index_second",  {8'h00, want.index_second},
                          {8'h00, got.index_second});
            compare_field("index_third",   {8'h00, want.index_third},
                          {8'h00, got.index_third});
            compare_field("index_fourth",  {8'h00, want.index_fourth},
                          {8'h00, got.index_fourth});
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    vertex_top4_board board = new();

    int words_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    top_four_weight_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #2_400_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver stall: switch between no stall, light, heavy and periodic stalls
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 80);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= ((stall_tick % 7) < 3);
            end
        endcase
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_word);
    end

    function automatic t_in_word pair_word(logic [BoneW-1:0] bone, logic [WeightW-1:0] w,
                                           logic has, logic lst);
        t_in_word x;
        x.bone_id  = bone;
        x.weight   = w;
        x.has_pair = has;
        x.last     = lst;
        return x;
    endfunction

    function automatic logic [WeightW-1:0] pick_weight();
        logic [WeightW-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = WeightW'($urandom_range(0, 16'hFFFF));
            4, 5:       w = WeightW'($urandom_range(0, 7));
            6: begin
                case ($urandom_range(0, 3))
                    0:       w = 16'h0000;
                    1:       w = 16'hFFFF;
                    2:       w = 16'h8000;
                    default: w = 16'h7FFF;
                endcase
            end
            default:    w = WeightW'($urandom_range(0, 16'h8000));
        endcase
        return w;
    endfunction

    // Send one word, opening a new burst after a random gap when one runs out
    task automatic push_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(w);
        if (w.has_pair || w.last) words_sent++;
    endtask

    // Send one vertex of random pairs, with stray empty words mixed in
    task automatic send_vertex();
        int                 n_pairs;
        int                 pick;
        bit                 close_empty;
        logic [BoneW-1:0]   bone;
        pick        = $urandom_range(0, 19);
        close_empty = ($urandom_range(0, 7) == 0);
        bone        = BoneW'($urandom_range(0, 255));
        if (pick == 0)       n_pairs = 0;
        else if (pick < 15)  n_pairs = $urandom_range(1, 5);
        else if (pick < 19)  n_pairs = $urandom_range(6, 10);
        else                 n_pairs = $urandom_range(11, 20);
        if (n_pairs == 0) close_empty = 1'b1;
        for (int k = 0; k < n_pairs; k++) begin
            if ($urandom_range(0, 11) == 0)
                push_word(pair_word(BoneW'($urandom_range(0, 255)),
                                    WeightW'($urandom_range(0, 16'hFFFF)),
                                    1'b0, 1'b0));
            push_word(pair_word(bone, pick_weight(), 1'b1,
                                !close_empty && (k == n_pairs - 1)));
            if ($urandom_range(0, 9) == 0) bone = BoneW'($urandom_range(0, 255));
            else                           bone = BoneW'(bone + $urandom_range(1, 16));
        end
        if (close_empty)
            push_word(pair_word(BoneW'($urandom_range(0, 255)),
                                WeightW'($urandom_range(0, 16'hFFFF)),
                                1'b0, 1'b1));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Vertex without weights
        push_word(pair_word(8'h00, 16'h0000, 1'b0, 1'b1));
        // Single pair at the top of both ranges, pair carried on the last word
        push_word(pair_word(8'hFF, 16'hFFFF, 1'b1, 1'b1));
        // Zero weight still fills a slot
        push_word(pair_word(8'h00, 16'h0000, 1'b1, 1'b1));
        // Ties keep arrival order; a larger pair pushes the smallest out,
        // an equal or smaller one is dropped once the slots are full
        push_word(pair_word(8'd1, 16'd100, 1'b1, 1'b0));
        push_word(pair_word(8'd2, 16'd300, 1'b1, 1'b0));
        push_word(pair_word(8'd3, 16'd300, 1'b1, 1'b0));
        push_word(pair_word(8'd4, 16'd50,  1'b1, 1'b0));
        push_word(pair_word(8'd5, 16'd300, 1'b1, 1'b0));
        push_word(pair_word(8'd6, 16'd300, 1'b1, 1'b0));
        push_word(pair_word(8'd7, 16'd0,   1'b1, 1'b1));
        // Empty words inside a vertex store nothing; empty last word closes it
        push_word(pair_word(8'd10, 16'h8000, 1'b1, 1'b0));
        push_word(pair_word(8'hAA, 16'h5555, 1'b0, 1'b0));
        push_word(pair_word(8'd11, 16'h7FFF, 1'b1, 1'b0));
        push_word(pair_word(8'h55, 16'hAAAA, 1'b0, 1'b1));
        // Repeated and unordered bone indices
        push_word(pair_word(8'd200, 16'd5, 1'b1, 1'b0));
        push_word(pair_word(8'd200, 16'd5, 1'b1, 1'b0));
        push_word(pair_word(8'd3,   16'd9, 1'b1, 1'b0));
        push_word(pair_word(8'd3,   16'd9, 1'b1, 1'b1));
        // Exactly four pairs rising, so each one lands at the head
        push_word(pair_word(8'd20, 16'h0001, 1'b1, 1'b0));
        push_word(pair_word(8'd21, 16'h0100, 1'b1, 1'b0));
        push_word(pair_word(8'd22, 16'h4000, 1'b1, 1'b0));
        push_word(pair_word(8'd23, 16'hFFFE, 1'b1, 1'b1));

        words_sent = 0;
        while (words_sent < 700) send_vertex();
        i_in_valid <= 1'b0;

        // Drain, then give the block a few cycles for any stray word
        while (board.due_sets.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (board.n_bad == 0 && board.due_sets.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tfws_pkg.sv
hw/rtl/tfws_cell.sv
hw/rtl/top_four_weight_select.sv
tb/tb_top_four_weight_select.sv
